FILE: sv/gf2m_multiply_power_core_macros.svh
// Assertion macros shared by the GF(2^m) multiply and power core.
`ifndef GF2M_MULTIPLY_POWER_CORE_MACROS_SVH
`define GF2M_MULTIPLY_POWER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GFMP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gfmp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GFMP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gfmp assertion failed");

`endif

FILE: sv/gfmp_pkg.sv
// Package with the types, codes and constants of the GF(2^m) multiply and power core.
package gfmp_pkg;

    // Default for the largest supported field degree.
    localparam int MAX_DEGREE_DEF = 8;

    // Fixed field widths.
    localparam int OPND_W      = 8;
    localparam int EXP_W       = 8;
    localparam int RES_W       = 8;
    localparam int MOD_W       = 9;
    localparam int DEG_W       = 4;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 1;

    // Operation codes.
    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_MUL = 2'd1;
    localparam logic [1:0] FUNC_POW = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_MODULUS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEGREE  = 1'b1;

    // Configuration reset values.
    localparam logic [MOD_W-1:0] MODULUS_RST = 9'd283;
    localparam logic [DEG_W-1:0] DEGREE_RST  = 4'd8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul_acc;
        logic sqr;
        logic finish;
    } gfmp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic exp_zero;
        logic exp_lsb;
    } gfmp_status_t;

endpackage

FILE: sv/gf2m_multiply_power_core.sv
// Top level of the GF(2^m) add, multiply and power core.
//
// Input channel in_valid/in_ready carries func, operand_a, operand_b and exponent;
// output channel out_valid/out_ready carries result. A config write (cfg_we with
// cfg_index and cfg_wdata) sets modulus_poly (index 0) or field_degree (index 1);
// the user must make it only while the core is idle; the core does not enforce it.
// One item is worked on at a time; in_ready is high only when no item is running.
// After acceptance a run loads the operands, multiplies the accumulator by the base
// for each set exponent bit and squares the base for each shift of the exponent,
// then finishes once the exponent is zero; add loads a zero exponent and multiply
// an exponent of one. The next transaction is accepted once the core is back in idle.
// The combinational field multiplier is shared by the accumulator multiply and squaring.
// Results go to an output register; the core takes the next item while a result
// waits there. When the receiver stalls, a finished run holds until the output
// register is free and input is not accepted meanwhile.
// Reset sets modulus_poly to 283, field_degree to 8 and clears the output valid.
module gf2m_multiply_power_core
    import gfmp_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             func,
    input  logic [OPND_W-1:0]      operand_a,
    input  logic [OPND_W-1:0]      operand_b,
    input  logic [EXP_W-1:0]       exponent,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [RES_W-1:0]       result
);

    gfmp_cmd_t    cmd;
    gfmp_status_t status;

    // Sequencer.
    gfmp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Registers and arithmetic.
    gfmp_datapath #(
        .MAX_DEGREE(MAX_DEGREE)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .func     (func),
        .operand_a(operand_a),
        .operand_b(operand_b),
        .exponent (exponent),
        .cmd      (cmd),
        .status   (status),
        .result   (result)
    );

endmodule

FILE: sv/gfmp_mul.sv
// Combinational GF(2^m) multiplier with interleaved modular reduction.
module gfmp_mul
    import gfmp_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
)
(
    input  logic [MAX_DEGREE-1:0] mul_a,
    input  logic [MAX_DEGREE-1:0] mul_b,
    input  logic [MAX_DEGREE:0]   lead,
    input  logic [MAX_DEGREE:0]   full,
    output logic [MAX_DEGREE-1:0] prod
);

    // Shift-and-add from the top bit of mul_b; leading zero bits leave the sum at zero.
    always_comb
    begin
        logic [MAX_DEGREE:0] r;
        r = '0;
        for (int i = MAX_DEGREE - 1; i >= 0; i--)
        begin
            r = r << 1;
            if (|(r & lead))
            begin
                r = r ^ full;
            end
            if (mul_b[i])
            begin
                r = r ^ {1'b0, mul_a};
            end
        end
        prod = r[MAX_DEGREE-1:0];
    end

endmodule

FILE: sv/gfmp_datapath.sv
// Datapath: configuration registers, operand registers, exponent register, result register and multiplier.
`include "gf2m_multiply_power_core_macros.svh"

module gfmp_datapath
    import gfmp_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [1:0]             func,
    input  logic [OPND_W-1:0]      operand_a,
    input  logic [OPND_W-1:0]      operand_b,
    input  logic [EXP_W-1:0]       exponent,
    input  gfmp_cmd_t              cmd,
    output gfmp_status_t           status,
    output logic [RES_W-1:0]       result
);

    localparam int W  = MAX_DEGREE;
    localparam int DW = $clog2(MAX_DEGREE + 1);
    localparam int CW = (DW > DEG_W) ? DW : DEG_W;

    logic [MOD_W-1:0] modulus_reg;
    logic [DEG_W-1:0] degree_reg;
    logic [W-1:0]     acc_reg, acc_next;
    logic [W-1:0]     base_reg, base_next;
    logic [EXP_W-1:0] exp_reg, exp_next;
    logic [RES_W-1:0] result_reg, result_next;

    logic [CW-1:0]    deg_ext;
    logic [CW-1:0]    m_eff;
    logic [W-1:0]     mask;
    logic [W:0]       lead;
    logic [W:0]       mod_ext;
    logic [W:0]       full;
    logic [W-1:0]     a_ext, b_ext;
    logic [W-1:0]     a_m, b_m;
    logic [W-1:0]     mul_a, prod;
    logic [RES_W-1:0] acc_res;

    // Configuration registers; the user must write them only while the core is idle, the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RST;
            degree_reg  <= DEGREE_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MODULUS)
            begin
                modulus_reg <= cfg_wdata[MOD_W-1:0];
            end
            else
            begin
                degree_reg <= cfg_wdata[DEG_W-1:0];
            end
        end
    end

    // Effective degree, clamped to the supported range.
    assign deg_ext = CW'(degree_reg);

    always_comb
    begin
        if (deg_ext < CW'(2))
        begin
            m_eff = CW'(2);
        end
        else if (deg_ext > CW'(MAX_DEGREE))
        begin
            m_eff = CW'(MAX_DEGREE);
        end
        else
        begin
            m_eff = deg_ext;
        end
    end

    // Element mask and one-hot leading term of the modulus.
    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            mask[i] = (CW'(i) < m_eff);
        end
        for (int i = 0; i <= W; i++)
        begin
            lead[i] = (CW'(i) == m_eff);
        end
    end

    // Width adaptation between the fixed fields and the element width.
    generate
        if (W + 1 >= MOD_W)
        begin : g_mod_wide
            assign mod_ext = (W + 1)'(modulus_reg);
        end
        else
        begin : g_mod_narrow
            assign mod_ext = modulus_reg[W:0];
        end

        if (W >= OPND_W)
        begin : g_opnd_wide
            assign a_ext = W'(operand_a);
            assign b_ext = W'(operand_b);
        end
        else
        begin : g_opnd_narrow
            assign a_ext = operand_a[W-1:0];
            assign b_ext = operand_b[W-1:0];
        end

        if (W >= RES_W)
        begin : g_res_wide
            assign acc_res = acc_reg[RES_W-1:0];
        end
        else
        begin : g_res_narrow
            assign acc_res = RES_W'(acc_reg);
        end
    endgenerate

    // Reduction polynomial with only the bits below m and the leading term set.
    assign full = (mod_ext & {1'b0, mask}) | lead;
    assign a_m  = a_ext & mask;
    assign b_m  = b_ext & mask;

    // Shared multiplier: accumulator times base, or base squared.
    assign mul_a = cmd.sqr ? base_reg : acc_reg;

    gfmp_mul #(
        .MAX_DEGREE(MAX_DEGREE)
    ) u_mul (
        .mul_a(mul_a),
        .mul_b(base_reg),
        .lead (lead),
        .full (full),
        .prod (prod)
    );

    // Next values of the working registers.
    always_comb
    begin
        acc_next    = acc_reg;
        base_next   = base_reg;
        exp_next    = exp_reg;
        result_next = result_reg;
        if (cmd.load)
        begin
            unique case (func)
                FUNC_ADD:
                begin
                    acc_next = a_m ^ b_m;
                    exp_next = '0;
                end
                FUNC_MUL:
                begin
                    acc_next  = a_m;
                    base_next = b_m;
                    exp_next  = EXP_W'(1);
                end
                FUNC_POW:
                begin
                    acc_next  = W'(1);
                    base_next = a_m;
                    exp_next  = exponent;
                end
                default:
                begin
                    acc_next = '0;
                    exp_next = '0;
                end
            endcase
        end
        else if (cmd.mul_acc)
        begin
            acc_next    = prod;
            exp_next[0] = 1'b0;
        end
        else if (cmd.sqr)
        begin
            base_next = prod;
            exp_next  = exp_reg >> 1;
        end
        if (cmd.finish)
        begin
            result_next = acc_res;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        base_reg   <= base_next;
        exp_reg    <= exp_next;
        result_reg <= result_next;
    end

    assign status.exp_zero = (exp_reg == '0);
    assign status.exp_lsb  = exp_reg[0];
    assign result          = result_reg;

    // A multiply into the accumulator consumes the low exponent bit.
    `GFMP_ASSERT_NEXT(a_mul_clears_lsb, cmd.mul_acc, !exp_reg[0])
    // A squaring step halves the remaining exponent.
    `GFMP_ASSERT_NEXT(a_sqr_shifts_exp, cmd.sqr, exp_reg == ($past(exp_reg) >> 1))

endmodule

FILE: sv/gfmp_ctrl.sv
// Controller: sequences the load, multiply and square steps and owns the output valid.
`include "gf2m_multiply_power_core_macros.svh"

module gfmp_ctrl
    import gfmp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  gfmp_status_t status,
    output gfmp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Step selection: multiply on a set exponent bit, otherwise square and shift.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (!status.exp_zero)
                begin
                    if (status.exp_lsb)
                    begin
                        cmd.mul_acc = 1'b1;
                    end
                    else
                    begin
                        cmd.sqr = 1'b1;
                    end
                end
                else if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register valid: set on finish, cleared when the transaction completes.
    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A finish never overwrites a result that is still waiting.
    `GFMP_ASSERT_SAME(a_no_overwrite, cmd.finish, !out_valid_reg || out_ready)
    // An accepted transaction always starts a run.
    `GFMP_ASSERT_NEXT(a_load_runs, in_valid && in_ready, state_reg == S_RUN)
    // The shared multiplier serves one step at a time.
    `GFMP_ASSERT_SAME(a_one_mul_step, cmd.mul_acc, !cmd.sqr && !cmd.load)
    // A finish always raises the output valid.
    `GFMP_ASSERT_NEXT(a_finish_valid, cmd.finish, out_valid_reg)

endmodule

FILE: bench/gf2m_multiply_power_core_tb.sv
// Self-checking testbench for the GF(2^m) add, multiply and power core.
module gf2m_multiply_power_core_tb;
    import gfmp_pkg::*;

    // The selector value that names no operation; the core answers it with zero.
    localparam logic [1:0] FUNC_NONE = 2'd3;

    localparam int PHASE_COUNT      = 9;
    localparam int OPS_PER_PHASE    = 170;
    localparam int DRAIN_CYCLES     = 40;
    localparam int CYCLE_LIMIT      = 600000;

    typedef struct packed {
        logic [1:0]        func;
        logic [OPND_W-1:0] a;
        logic [OPND_W-1:0] b;
        logic [EXP_W-1:0]  e;
    } field_op_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [1:0]             func = '0;
    logic [OPND_W-1:0]      operand_a = '0;
    logic [OPND_W-1:0]      operand_b = '0;
    logic [EXP_W-1:0]       exponent = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [RES_W-1:0]       result;

    // Operations waiting to be sent and field elements the core still owes.
    field_op_t        pending_ops[$];
    logic [RES_W-1:0] results_due[$];
    field_op_t        op_on_bus;
    logic [RES_W-1:0] owed_result;

    // Shadow copy of the configuration registers.
    logic [MOD_W-1:0] modulus_cfg = MODULUS_RST;
    logic [DEG_W-1:0] degree_cfg  = DEGREE_RST;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;

    gf2m_multiply_power_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .exponent  (exponent),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Carry-less multiply, top bit of y first, reducing as it goes.
    // Bit m of the polynomial is always taken as set; bits above m are dropped.
    function automatic logic [RES_W-1:0] field_mul(logic [OPND_W-1:0] x, logic [OPND_W-1:0] y,
                                                   int unsigned m, logic [MOD_W-1:0] poly);
        logic [MOD_W-1:0] mask;
        logic [MOD_W-1:0] full;
        logic [MOD_W-1:0] acc;
        mask = (MOD_W'(1) << m) - MOD_W'(1);
        full = (poly & mask) | (MOD_W'(1) << m);
        acc  = '0;
        for (int i = m; i > 0; i--)
        begin
            acc = acc << 1;
            if (acc[m])
                acc = acc ^ full;
            if (y[i-1])
                acc = acc ^ {1'b0, x & mask[OPND_W-1:0]};
        end
        return acc[RES_W-1:0] & mask[RES_W-1:0];
    endfunction

    // Square-and-multiply over all eight exponent bits; exponent zero gives one.
    function automatic logic [RES_W-1:0] field_pow(logic [OPND_W-1:0] x, logic [EXP_W-1:0] e,
                                                   int unsigned m, logic [MOD_W-1:0] poly);
        logic [RES_W-1:0] acc;
        logic [RES_W-1:0] base;
        acc  = RES_W'(1);
        base = x;
        for (int i = 0; i < EXP_W; i++)
        begin
            if (e[i])
                acc = field_mul(acc, base, m, poly);
            base = field_mul(base, base, m, poly);
        end
        return acc;
    endfunction

    // Field element the core must return for one operation under the current setup.
    function automatic logic [RES_W-1:0] compute_field_result(field_op_t op,
                                                              logic [MOD_W-1:0] poly,
                                                              logic [DEG_W-1:0] degree);
        int unsigned      m;
        logic [RES_W-1:0] mask;
        logic [OPND_W-1:0] a;
        logic [OPND_W-1:0] b;
        m = degree;
        if (m < 2)
            m = 2;
        if (m > MAX_DEGREE_DEF)
            m = MAX_DEGREE_DEF;
        mask = RES_W'((9'd1 << m) - 9'd1);
        a = op.a & mask;
        b = op.b & mask;
        case (op.func)
            FUNC_ADD: return (a ^ b) & mask;
            FUNC_MUL: return field_mul(a, b, m, poly);
            FUNC_POW: return field_pow(a, op.e, m, poly) & mask;
            default:  return '0;
        endcase
    endfunction

    task automatic flag_mismatch(string msg);
        error_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic queue_op(logic [1:0] f, logic [OPND_W-1:0] a, logic [OPND_W-1:0] b,
                            logic [EXP_W-1:0] e);
        field_op_t op;
        op.func = f;
        op.a    = a;
        op.b    = b;
        op.e    = e;
        pending_ops.push_back(op);
    endtask

    // Configuration writes are only made while the core is idle.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MODULUS)
            modulus_cfg = data[MOD_W-1:0];
        else
            degree_cfg = data[DEG_W-1:0];
    endtask

    // Checked at the falling edge so that all clocked updates have settled.
    task automatic wait_quiet();
        @(negedge clk);
        while (pending_ops.size() != 0 || in_valid || results_due.size() != 0)
            @(negedge clk);
    endtask

    // Input driver: predicts each accepted transaction, then presents the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                results_due.push_back(compute_field_result(op_on_bus, modulus_cfg, degree_cfg));
            if (!in_valid || in_ready)
            begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    op_on_bus = pending_ops.pop_front();
                    in_valid  <= 1'b1;
                    func      <= op_on_bus.func;
                    operand_a <= op_on_bus.a;
                    operand_b <= op_on_bus.b;
                    exponent  <= op_on_bus.e;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: compares each result transaction with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    flag_mismatch($sformatf("result 0x%02h with nothing expected", result));
                end
                else
                begin
                    owed_result = results_due.pop_front();
                    if (result !== owed_result)
                        flag_mismatch($sformatf("result 0x%02h, expected 0x%02h",
                                                result, owed_result));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("gf2m_multiply_power_core_tb: done, errors");
            $finish;
        end
    end

    // Stimulus: directed cases under the reset setup, then random phases.
    initial
    begin
        int unsigned      pick;
        logic [1:0]       f;
        logic [EXP_W-1:0] e;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Field extremes, every operation, and the special cases at the reset polynomial.
        queue_op(FUNC_ADD, 8'h00, 8'h00, 8'h00);
        queue_op(FUNC_ADD, 8'hFF, 8'hFF, 8'hFF);
        queue_op(FUNC_ADD, 8'hAA, 8'h55, 8'h00);
        queue_op(FUNC_ADD, 8'hF0, 8'h0F, 8'hFF);
        queue_op(FUNC_MUL, 8'h00, 8'hFF, 8'h00);
        queue_op(FUNC_MUL, 8'hFF, 8'h00, 8'hFF);
        queue_op(FUNC_MUL, 8'h01, 8'hB7, 8'h00);
        queue_op(FUNC_MUL, 8'hFF, 8'hFF, 8'h00);
        queue_op(FUNC_MUL, 8'h53, 8'hCA, 8'h00);
        queue_op(FUNC_MUL, 8'h80, 8'h80, 8'h00);
        queue_op(FUNC_MUL, 8'h57, 8'h83, 8'hFF);
        queue_op(FUNC_POW, 8'h00, 8'h00, 8'h00);
        queue_op(FUNC_POW, 8'h53, 8'hFF, 8'h00);
        queue_op(FUNC_POW, 8'h00, 8'h00, 8'h05);
        queue_op(FUNC_POW, 8'h03, 8'h00, 8'hFF);
        queue_op(FUNC_POW, 8'h02, 8'h00, 8'h01);
        queue_op(FUNC_POW, 8'hFF, 8'hFF, 8'hFE);
        queue_op(FUNC_POW, 8'h80, 8'h00, 8'h80);
        queue_op(FUNC_POW, 8'h01, 8'h00, 8'hFF);
        queue_op(FUNC_NONE, 8'hFF, 8'hFF, 8'hFF);
        queue_op(FUNC_NONE, 8'h00, 8'h00, 8'h00);
        queue_op(FUNC_NONE, 8'h5A, 8'hA5, 8'h3C);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase != 0)
            begin
                wait_quiet();
                // Settings cover degrees below and above the supported range,
                // a zero polynomial and polynomials with bits above the degree.
                case (phase)
                    1: begin write_reg(REG_MODULUS, 9'd285); write_reg(REG_DEGREE, 9'd8);  end
                    2: begin write_reg(REG_MODULUS, 9'd19);  write_reg(REG_DEGREE, 9'd4);  end
                    3: begin write_reg(REG_MODULUS, 9'd511); write_reg(REG_DEGREE, 9'd0);  end
                    4: begin write_reg(REG_MODULUS, 9'd0);   write_reg(REG_DEGREE, 9'd15); end
                    5: begin write_reg(REG_MODULUS, 9'd7);   write_reg(REG_DEGREE, 9'd2);  end
                    6: begin write_reg(REG_MODULUS, 9'h1FB); write_reg(REG_DEGREE, 9'd3);  end
                    7: begin write_reg(REG_MODULUS, 9'd37);  write_reg(REG_DEGREE, 9'd5);  end
                    default:
                    begin
                        write_reg(REG_MODULUS, CFG_DATA_W'($urandom_range(0, 511)));
                        write_reg(REG_DEGREE, CFG_DATA_W'($urandom_range(0, 15)));
                    end
                endcase
            end

            // Rotate through no idling, sender gaps, receiver stalls, and both.
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase

            for (int n = 0; n < OPS_PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 15);
                if (pick == 15)
                    f = FUNC_NONE;
                else if (pick % 3 == 0)
                    f = FUNC_ADD;
                else if (pick % 3 == 1)
                    f = FUNC_MUL;
                else
                    f = FUNC_POW;
                // Small and all-ones exponents show up more often than a flat draw gives.
                case ($urandom_range(0, 3))
                    0:       e = EXP_W'($urandom_range(0, 3));
                    1:       e = 8'hFF;
                    default: e = EXP_W'($urandom);
                endcase
                queue_op(f, OPND_W'($urandom), OPND_W'($urandom), e);
            end
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (results_due.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", results_due.size()));
        if (error_count == 0)
            $display("gf2m_multiply_power_core_tb: done, clean");
        else
            $display("gf2m_multiply_power_core_tb: done, errors");
        $finish;
    end

endmodule
